// ----- hdl/kms_pkg.sv -----
// kms_pkg: shared sizes, register indexes and helpers of the key matrix scanner
`default_nettype none

package kms_pkg;

    localparam int ROWS      = 6;
    localparam int COLS      = 8;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 8;
    localparam int KEY_W     = 48;
    localparam int CNT_W     = 16;
    localparam int CIDX_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS  = 2'd2;

    localparam logic [CNT_W-1:0] SETTLE_RST = 16'd3;
    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd655;

    localparam logic [COL_W-1:0] COL_MASK = COL_W'((64'd1 << COLS) - 64'd1);

    typedef logic [KEY_W-1:0] t_keys;
    typedef logic [COL_W-1:0] t_cols;

    // all used columns high except column c, which is driven low
    function automatic t_cols one_low(input logic [CIDX_W-1:0] c);
        return COL_MASK & ~(t_cols'(1) << c);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/key_matrix_scanner_unit.sv -----
// key_matrix_scanner_unit: key matrix scan sequencer with registered result
// How it is used:
//   - input channel (i_in_valid / o_in_ready) carries one request per tick of the
//     32768 Hz timebase, holding the sampled row pin levels i_row_levels
//   - output channel (o_out_valid / i_out_ready) returns exactly one result per
//     request: column drive, report flag, key bitmap and wake-armed flag
//   - configuration port (i_cfg_we / i_cfg_index / i_cfg_data) writes settle
//     ticks, period ticks and the press level; settle and period take effect on
//     the next wait started, the press level on later requests; index 3 is ignored
// Result timing and rate:
//   - a result is registered in the cycle after its request is accepted
//   - one request per cycle while i_out_ready stays high; each request checks
//     for a wake while armed, counts down the wait or performs one scan step, all
//     in one combinational pass from the scan state registers to the result register
// Reset (i_rst_n low, synchronous):
//   - block comes up armed, all columns low, no result pending, registers at
//     settle 3, period 655, press level 0
// Receiver stall:
//   - the result register holds while i_out_ready is low; a new request is taken
//     only when the result register is empty or is being emptied that same cycle
`default_nettype none

module key_matrix_scanner_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [kms_pkg::ROW_W-1:0]        i_row_levels,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [kms_pkg::COL_W-1:0]             o_col_drive,
    output logic                                  o_report_valid,
    output logic [kms_pkg::KEY_W-1:0]             o_keys,
    output logic                                  o_wake_armed,
    // configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [kms_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [kms_pkg::CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SCAN  = 2'd1,
        PH_REARM = 2'd2
    } t_phase;

    // configuration registers
    logic [kms_pkg::CNT_W-1:0] r_settle;
    logic [kms_pkg::CNT_W-1:0] r_period;
    logic                      r_press;

    // scan state
    t_phase                     r_phase,   n_phase;
    logic                       r_armed,   n_armed;
    logic [kms_pkg::CIDX_W-1:0] r_col_idx, n_col_idx;
    kms_pkg::t_keys             r_acc,     n_acc;
    logic [kms_pkg::CNT_W-1:0]  r_cnt,     n_cnt;
    kms_pkg::t_cols             r_col_lv,  n_col_lv;

    // result register
    logic                       r_out_valid;
    kms_pkg::t_cols             r_col_drive;
    logic                       r_rep_valid, n_rep_valid;
    kms_pkg::t_keys             r_keys,      n_keys;
    logic                       r_wake;

    logic                       in_accept;
    logic [kms_pkg::ROWS-1:0]   pressed;
    kms_pkg::t_keys             hits;
    kms_pkg::t_keys             scan_keys;
    logic                       fire;
    logic                       last_col;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // a row is pressed when its sampled level equals the press level
    always_comb begin
        for (int r = 0; r < kms_pkg::ROWS; r++) begin
            pressed[r] = (i_row_levels[r] == r_press);
        end
    end

    // key bits for the column under scan: row r lands at bit r*COLS+col
    always_comb begin
        for (int r = 0; r < kms_pkg::ROWS; r++) begin
            hits[r*kms_pkg::COLS +: kms_pkg::COLS] = pressed[r]
                ? (kms_pkg::COLS'(1) << r_col_idx) : '0;
        end
    end

    assign scan_keys = r_acc | hits;
    assign last_col  = (32'(r_col_idx) + 32'd1 >= kms_pkg::COLS);

    // next scan state and result for one tick
    always_comb begin
        n_phase     = r_phase;
        n_armed     = r_armed;
        n_col_idx   = r_col_idx;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_col_lv    = r_col_lv;
        n_rep_valid = 1'b0;
        n_keys      = '0;
        fire        = 1'b0;

        // wake check while armed, else count down the running wait
        if (r_armed) begin
            if (|pressed) begin
                n_armed = 1'b0;
                fire    = 1'b1;
            end
        end else if (r_cnt > kms_pkg::CNT_W'(1)) begin
            n_cnt = r_cnt - kms_pkg::CNT_W'(1);
        end else begin
            fire = 1'b1;
        end

        if (fire) begin
            case (r_phase)
                PH_SCAN: begin
                    // sample this column, then move on or finish the scan
                    n_col_idx = r_col_idx + kms_pkg::CIDX_W'(1);
                    if (!last_col) begin
                        n_acc    = scan_keys;
                        n_col_lv = kms_pkg::one_low(r_col_idx + kms_pkg::CIDX_W'(1));
                        n_cnt    = r_settle;
                    end else begin
                        n_rep_valid = 1'b1;
                        n_keys      = scan_keys;
                        if (scan_keys != '0) begin
                            // keys held: release columns, rescan after the period
                            n_col_lv = kms_pkg::COL_MASK;
                            n_cnt    = r_period;
                            n_phase  = PH_IDLE;
                        end else begin
                            // all released: columns low, re-arm after settling
                            n_col_lv = '0;
                            n_cnt    = r_settle;
                            n_phase  = PH_REARM;
                        end
                        n_acc     = '0;
                        n_col_idx = '0;
                    end
                end
                PH_REARM: begin
                    n_armed = 1'b1;
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                end
                default: begin
                    // start a scan on the current column
                    n_col_lv = kms_pkg::one_low(r_col_idx);
                    n_cnt    = r_settle;
                    n_phase  = PH_SCAN;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= kms_pkg::SETTLE_RST;
            r_period <= kms_pkg::PERIOD_RST;
            r_press  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kms_pkg::CFG_SETTLE: r_settle <= i_cfg_data;
                kms_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                kms_pkg::CFG_PRESS:  r_press  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // scan state, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_armed   <= 1'b1;
            r_col_idx <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_col_lv  <= '0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_armed   <= n_armed;
            r_col_idx <= n_col_idx;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_col_lv  <= n_col_lv;
        end
    end

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col_drive <= n_col_lv;
            r_rep_valid <= n_rep_valid;
            r_keys      <= n_keys;
            r_wake      <= n_armed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_col_drive    = r_col_drive;
    assign o_report_valid = r_rep_valid;
    assign o_keys         = r_keys;
    assign o_wake_armed   = r_wake;

    // armed only ever waits in the idle phase
    a_armed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_phase == PH_IDLE)
        else $error("armed outside idle phase");

    // during a scan exactly one column is driven low
    a_scan_one_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SCAN |-> $countones(r_col_lv) == kms_pkg::COLS - 1)
        else $error("scan column drive not one-low");

    // armed state always has all columns low
    a_armed_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> r_col_lv == '0)
        else $error("armed with columns not all low");

    // no key bits outside a report
    a_keys_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !n_rep_valid |=> o_keys == '0)
        else $error("keys set without report");

    // accumulator is cleared at every scan boundary
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_rep_valid |=> r_acc == '0 && r_col_idx == '0)
        else $error("scan state not cleared after report");

endmodule

`default_nettype wire
